[rtl/core/assert_macros.svh]
// Assertion helpers for the frame receiver.
// Each expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define STX_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define STX_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STX_ASSERT_SAME(name, ante, cons, msg)

`define STX_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

[rtl/core/stxlfr_pkg.sv]
package stxlfr_pkg;

    localparam logic [7:0]  START_BYTE       = 8'h02;
    localparam logic [15:0] MAX_LEN_RESET    = 16'd1024;
    localparam logic [15:0] TICK_LIMIT_RESET = 16'd2000;
    localparam logic [16:0] HEADER_BYTES     = 17'd4;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CMD    = 3'd1,
        PH_SUBCMD = 3'd2,
        PH_LENHI  = 3'd3,
        PH_LENLO  = 3'd4,
        PH_DATA   = 3'd5,
        PH_CHK1   = 3'd6,
        PH_CHK2   = 3'd7
    } phase_t;

    localparam logic [2:0] FK_CMD    = 3'd0;
    localparam logic [2:0] FK_SUBCMD = 3'd1;
    localparam logic [2:0] FK_LENHI  = 3'd2;
    localparam logic [2:0] FK_LENLO  = 3'd3;
    localparam logic [2:0] FK_DATA   = 3'd4;
    localparam logic [2:0] FK_CHK1   = 3'd5;
    localparam logic [2:0] FK_CHK2   = 3'd6;

    localparam logic [1:0] ST_BYTE     = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic REG_MAX_LEN    = 1'b0;
    localparam logic REG_TICK_LIMIT = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [16:0] byte_index;
        logic [2:0]  field_kind;
        logic [1:0]  status;
        logic        last;
    } res_item_t;

    typedef struct packed {
        logic [15:0] max_payload_length;
        logic [15:0] idle_tick_limit;
    } cfg_t;

endpackage

[rtl/core/stxlfr_regs.sv]
`include "assert_macros.svh"

module stxlfr_regs
    import stxlfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic        wr_en;
    logic [15:0] max_len_reg;
    logic [15:0] tick_limit_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // low address bits are a byte offset within the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= MAX_LEN_RESET;
            tick_limit_reg <= TICK_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_MAX_LEN:    max_len_reg    <= pwdata[15:0];
                REG_TICK_LIMIT: tick_limit_reg <= pwdata[15:0];
                default:        max_len_reg    <= max_len_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MAX_LEN:    prdata = {16'd0, max_len_reg};
            REG_TICK_LIMIT: prdata = {16'd0, tick_limit_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.max_payload_length = max_len_reg;
    assign cfg.idle_tick_limit    = tick_limit_reg;

    `STX_ASSERT_NEXT(a_max_len_write, wr_en && (paddr[2] == REG_MAX_LEN),
        max_len_reg == $past(pwdata[15:0]), "max length write lost")
    `STX_ASSERT_NEXT(a_limit_write, wr_en && (paddr[2] == REG_TICK_LIMIT),
        tick_limit_reg == $past(pwdata[15:0]), "tick limit write lost")
    `STX_ASSERT_NEXT(a_regs_hold, !wr_en,
        $stable(max_len_reg) && $stable(tick_limit_reg), "register changed without write")

endmodule

[rtl/core/stx_length_frame_receiver_top.sv]
// STX length-prefixed frame receiver. Each request is either a received byte or an idle
// tick. In idle the receiver waits for the start byte 0x02 and drops it; it then passes on
// command, subcommand, the big-endian 16-bit length, that many payload bytes and two check
// bytes, each tagged with its position in the frame and its field kind, the second check
// byte marking the frame complete. Check bytes are passed on unverified. A length above
// max_payload_length (register at 0x0) aborts the frame with an error result; more idle
// ticks than idle_tick_limit (register at 0x4) return it to idle, with a timeout result if
// a frame was open. A request is taken into an input register and handled, as soon as the
// result register can advance, by one state update that loads the result register, so one
// request is accepted per clock while the result register can advance.
// Requests that cause no result still pass through the input register in order.
`include "assert_macros.svh"

module stx_length_frame_receiver_top
    import stxlfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  rx_item_t    rx_item,
    output logic        res_valid,
    input  logic        res_ready,
    output res_item_t   res_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t        cfg;

    logic        stage_valid_reg;
    rx_item_t    stage_item_reg;
    logic        advance;

    phase_t      phase_reg,      phase_next;
    logic [16:0] byte_count_reg, byte_count_next;
    logic [15:0] frame_len_reg,  frame_len_next;
    logic [15:0] idle_ticks_reg, idle_ticks_next;

    logic        res_valid_reg;
    res_item_t   res_item_reg;
    logic        has_res;
    res_item_t   res_next;

    logic [16:0] count_inc;
    logic [16:0] data_end;
    logic [15:0] len_full;
    logic        tick_expired;
    logic        too_long;

    stxlfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance  = stage_valid_reg && (!res_valid_reg || res_ready);
    assign rx_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (rx_ready)
        begin
            stage_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            stage_item_reg <= rx_item;
        end
    end

    assign count_inc    = byte_count_reg + 17'd1;
    assign data_end     = {1'b0, frame_len_reg} + HEADER_BYTES;
    assign len_full     = {frame_len_reg[15:8], stage_item_reg.rx_byte};
    assign tick_expired = idle_ticks_reg >= cfg.idle_tick_limit;
    assign too_long     = len_full > cfg.max_payload_length;

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        frame_len_next  = frame_len_reg;
        idle_ticks_next = 16'd0;
        if (stage_item_reg.kind == KIND_TICK)
        begin
            if (tick_expired)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                idle_ticks_next = idle_ticks_reg + 16'd1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (stage_item_reg.rx_byte == START_BYTE)
                    begin
                        phase_next      = PH_CMD;
                        byte_count_next = 17'd0;
                    end
                end
                PH_CMD:
                begin
                    phase_next      = PH_SUBCMD;
                    byte_count_next = 17'd1;
                end
                PH_SUBCMD:
                begin
                    phase_next      = PH_LENHI;
                    byte_count_next = 17'd2;
                end
                PH_LENHI:
                begin
                    phase_next      = PH_LENLO;
                    byte_count_next = 17'd3;
                    frame_len_next  = {stage_item_reg.rx_byte, 8'd0};
                end
                PH_LENLO:
                begin
                    byte_count_next = HEADER_BYTES;
                    frame_len_next  = len_full;
                    if (too_long)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (len_full == 16'd0)
                    begin
                        phase_next = PH_CHK1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    byte_count_next = count_inc;
                    if (count_inc >= data_end)
                    begin
                        phase_next = PH_CHK1;
                    end
                end
                PH_CHK1:
                begin
                    byte_count_next = count_inc;
                    phase_next      = PH_CHK2;
                end
                PH_CHK2:
                begin
                    byte_count_next = count_inc;
                    phase_next      = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        has_res             = 1'b0;
        res_next.byte_value = stage_item_reg.rx_byte;
        res_next.byte_index = byte_count_reg;
        res_next.field_kind = FK_CMD;
        res_next.status     = ST_BYTE;
        res_next.last       = 1'b0;
        if (stage_item_reg.kind == KIND_TICK)
        begin
            has_res             = tick_expired && (phase_reg != PH_IDLE);
            res_next.byte_value = 8'd0;
            res_next.status     = ST_TIMEOUT;
            res_next.last       = 1'b1;
        end
        else
        begin
            has_res = phase_reg != PH_IDLE;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    has_res = 1'b0;
                end
                PH_CMD:
                begin
                    res_next.byte_index = 17'd0;
                    res_next.field_kind = FK_CMD;
                end
                PH_SUBCMD:
                begin
                    res_next.byte_index = 17'd1;
                    res_next.field_kind = FK_SUBCMD;
                end
                PH_LENHI:
                begin
                    res_next.byte_index = 17'd2;
                    res_next.field_kind = FK_LENHI;
                end
                PH_LENLO:
                begin
                    res_next.byte_index = 17'd3;
                    res_next.field_kind = FK_LENLO;
                    if (too_long)
                    begin
                        res_next.byte_value = 8'd0;
                        res_next.status     = ST_TOO_LONG;
                        res_next.last       = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    res_next.field_kind = FK_DATA;
                end
                PH_CHK1:
                begin
                    res_next.field_kind = FK_CHK1;
                end
                PH_CHK2:
                begin
                    res_next.field_kind = FK_CHK2;
                    res_next.status     = ST_COMPLETE;
                    res_next.last       = 1'b1;
                end
                default:
                begin
                    has_res = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_count_reg <= 17'd0;
            frame_len_reg  <= 16'd0;
            idle_ticks_reg <= 16'd0;
            res_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            frame_len_reg  <= frame_len_next;
            idle_ticks_reg <= idle_ticks_next;
            res_valid_reg  <= has_res;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_res)
        begin
            res_item_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `STX_ASSERT_NEXT(a_last_closes_frame, advance && has_res && res_next.last,
        phase_reg == PH_IDLE, "frame still open after last result")
    `STX_ASSERT_SAME(a_data_in_range, phase_reg == PH_DATA,
        (byte_count_reg >= HEADER_BYTES) && (byte_count_reg < data_end),
        "payload position outside frame length")
    `STX_ASSERT_SAME(a_complete_on_chk2, res_valid_reg,
        (res_item_reg.status == ST_COMPLETE) == (res_item_reg.field_kind == FK_CHK2),
        "completion not tied to second check byte")
    `STX_ASSERT_NEXT(a_accept_staged, rx_valid && rx_ready,
        stage_valid_reg, "accepted request not staged")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import stxlfr_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_LIMIT   = 20_000;
    localparam int SETTLE_CYCLES = 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        rx_valid  = 1'b0;
    logic        rx_ready;
    rx_item_t    rx_item   = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_item_t   res_item;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the receiver state and its registers
    phase_t      rx_phase       = PH_IDLE;
    logic [16:0] frame_pos      = '0;
    logic [15:0] frame_len      = '0;
    logic [15:0] tick_count     = '0;
    logic [15:0] cfg_max_len    = MAX_LEN_RESET;
    logic [15:0] cfg_tick_limit = TICK_LIMIT_RESET;

    res_item_t   pending_results[$];
    res_item_t   oldest_result;
    int          error_count   = 0;
    int          items_sent    = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    stx_length_frame_receiver_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_item   (rx_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic res_item_t pack_result(input logic [7:0] value, input logic [16:0] index,
                                              input logic [2:0] fkind, input logic [1:0] status,
                                              input logic last);
        res_item_t res;
        res.byte_value = value;
        res.byte_index = index;
        res.field_kind = fkind;
        res.status     = status;
        res.last       = last;
        return res;
    endfunction

    // Advance the shadow state by one request; returns 1 when a result is due
    function automatic bit frame_predict(input rx_item_t req, output res_item_t res);
        phase_t      was;
        logic [16:0] pos;
        res = '0;
        if (req.kind == KIND_TICK)
        begin
            if (tick_count >= cfg_tick_limit)
            begin
                was        = rx_phase;
                rx_phase   = PH_IDLE;
                tick_count = '0;
                if (was == PH_IDLE)
                    return 1'b0;
                res = pack_result(8'h00, frame_pos, FK_CMD, ST_TIMEOUT, 1'b1);
                return 1'b1;
            end
            tick_count = tick_count + 16'd1;
            return 1'b0;
        end
        tick_count = '0;
        pos        = frame_pos;
        case (rx_phase)
            PH_IDLE:
            begin
                if (req.rx_byte == START_BYTE)
                begin
                    rx_phase  = PH_CMD;
                    frame_pos = '0;
                end
                return 1'b0;
            end
            PH_CMD:
            begin
                frame_pos = 17'd1;
                rx_phase  = PH_SUBCMD;
                res = pack_result(req.rx_byte, 17'd0, FK_CMD, ST_BYTE, 1'b0);
            end
            PH_SUBCMD:
            begin
                frame_pos = 17'd2;
                rx_phase  = PH_LENHI;
                res = pack_result(req.rx_byte, 17'd1, FK_SUBCMD, ST_BYTE, 1'b0);
            end
            PH_LENHI:
            begin
                frame_pos = 17'd3;
                frame_len = {req.rx_byte, 8'h00};
                rx_phase  = PH_LENLO;
                res = pack_result(req.rx_byte, 17'd2, FK_LENHI, ST_BYTE, 1'b0);
            end
            PH_LENLO:
            begin
                frame_pos      = HEADER_BYTES;
                frame_len[7:0] = req.rx_byte;
                if (frame_len > cfg_max_len)
                begin
                    rx_phase = PH_IDLE;
                    res = pack_result(8'h00, 17'd3, FK_LENLO, ST_TOO_LONG, 1'b1);
                end
                else
                begin
                    rx_phase = (frame_len == 16'd0) ? PH_CHK1 : PH_DATA;
                    res = pack_result(req.rx_byte, 17'd3, FK_LENLO, ST_BYTE, 1'b0);
                end
            end
            PH_DATA:
            begin
                frame_pos = frame_pos + 17'd1;
                if (frame_pos >= {1'b0, frame_len} + HEADER_BYTES)
                    rx_phase = PH_CHK1;
                res = pack_result(req.rx_byte, pos, FK_DATA, ST_BYTE, 1'b0);
            end
            PH_CHK1:
            begin
                frame_pos = frame_pos + 17'd1;
                rx_phase  = PH_CHK2;
                res = pack_result(req.rx_byte, pos, FK_CHK1, ST_BYTE, 1'b0);
            end
            default:
            begin
                frame_pos = frame_pos + 17'd1;
                rx_phase  = PH_IDLE;
                res = pack_result(req.rx_byte, pos, FK_CHK2, ST_COMPLETE, 1'b1);
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [16:0] want,
                                        input logic [16:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none pending: value %0d index %0d kind %0d status %0d",
                       res_item.byte_value, res_item.byte_index, res_item.field_kind,
                       res_item.status);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("byte_value", 17'(oldest_result.byte_value),
                            17'(res_item.byte_value));
                check_field("byte_index", oldest_result.byte_index, res_item.byte_index);
                check_field("field_kind", 17'(oldest_result.field_kind),
                            17'(res_item.field_kind));
                check_field("status", 17'(oldest_result.status), 17'(res_item.status));
                check_field("last", 17'(oldest_result.last), 17'(res_item.last));
            end
        end
    end

    // Leaves valid high; the next request or a drain takes it over in the same step
    task automatic send_request(input rx_item_t req);
        res_item_t res;
        if ($urandom_range(99) < send_idle_pct)
        begin
            rx_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        rx_valid <= 1'b1;
        rx_item  <= req;
        do
            @(posedge clk);
        while (!rx_ready);
        if (frame_predict(req, res))
            pending_results.push_back(res);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] value);
        rx_item_t req;
        req.kind    = KIND_BYTE;
        req.rx_byte = value;
        send_request(req);
    endtask

    task automatic send_tick();
        rx_item_t req;
        req.kind    = KIND_TICK;
        req.rx_byte = 8'($urandom);
        send_request(req);
    endtask

    task automatic drain_results();
        int waited;
        rx_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
            pending_results.delete();
        end
        // let requests with no result clear the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [15:0] value);
        logic [31:0] word;
        word       = $urandom;
        word[15:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_sel == REG_MAX_LEN)
            cfg_max_len = value;
        else
            cfg_tick_limit = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(input logic [15:0] max_len, input logic [15:0] tick_limit);
        drain_results();
        write_reg(REG_MAX_LEN, max_len);
        write_reg(REG_TICK_LIMIT, tick_limit);
    endtask

    task automatic test_basic_frame();
        send_idle_pct = 24;
        recv_idle_pct = 46;
        // bytes in idle other than the start byte are dropped
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_BYTE);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h02);
        // start byte inside the payload is plain data
        send_byte(8'hFF);
        send_byte(START_BYTE);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_length_abort();
        // 0x0401 exceeds the reset maximum of 1024
        send_byte(START_BYTE);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h04);
        send_byte(8'h01);
        // zero length goes straight to the check bytes, even with a zero maximum
        set_limits(16'd0, TICK_LIMIT_RESET);
        send_byte(START_BYTE);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hC1);
        send_byte(8'hC2);
    endtask

    task automatic test_tick_timeout();
        set_limits(MAX_LEN_RESET, 16'd2);
        send_byte(START_BYTE);
        send_byte(8'h33);
        send_tick();
        send_tick();
        // a byte clears the tick count
        send_byte(8'h44);
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        // zero limit: every tick forces idle
        set_limits(MAX_LEN_RESET, 16'd0);
        send_tick();
        send_byte(START_BYTE);
        send_tick();
    endtask

    task automatic pick_random_limits();
        logic [15:0] max_len;
        logic [15:0] tick_limit;
        case ($urandom_range(3))
            0:       max_len = 16'($urandom_range(8));
            1:       max_len = 16'd0;
            2:       max_len = 16'hFFFF;
            default: max_len = 16'($urandom);
        endcase
        case ($urandom_range(3))
            0:       tick_limit = 16'($urandom_range(6, 1));
            1:       tick_limit = 16'd1;
            2:       tick_limit = 16'hFFFF;
            default: tick_limit = 16'($urandom_range(16));
        endcase
        set_limits(max_len, tick_limit);
    endtask

    task automatic send_random_frame();
        logic [15:0] len;
        int          roll;
        int          stop_at;
        int          ticks;
        repeat ($urandom_range(2))
        begin
            if ($urandom_range(1))
                send_tick();
            else
                send_byte(8'($urandom));
        end
        roll = $urandom_range(99);
        if (roll < 15 && cfg_max_len != 16'hFFFF)
            len = 16'($urandom_range(65535, int'(cfg_max_len) + 1));
        else if (roll < 25 && cfg_max_len <= 16'd8)
            len = cfg_max_len;
        else
            len = 16'($urandom_range(6));
        stop_at = ($urandom_range(9) == 0) ? $urandom_range(int'(len) + 5) : -1;
        send_byte(START_BYTE);
        for (int i = 0; i < int'(len) + 6; i++)
        begin
            if (i == stop_at || (i == 4 && len > cfg_max_len))
                break;
            if ($urandom_range(19) == 0)
            begin
                ticks = (cfg_tick_limit <= 16'd8) ? $urandom_range(int'(cfg_tick_limit) + 1, 1)
                                                  : $urandom_range(3, 1);
                repeat (ticks) send_tick();
            end
            if (i == 2)
                send_byte(len[15:8]);
            else if (i == 3)
                send_byte(len[7:0]);
            else
                send_byte(8'($urandom));
        end
        // broken frame: sometimes let it time out
        if (stop_at >= 0 && cfg_tick_limit <= 16'd16 && $urandom_range(9) < 3)
            repeat (int'(cfg_tick_limit) + 1) send_tick();
    endtask

    task automatic test_random_traffic();
        int phase_end;
        for (int m = 0; m < 3; m++)
        begin
            case (m)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 46;
                end
                1:
                begin
                    send_idle_pct = 46;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < 3; s++)
            begin
                pick_random_limits();
                phase_end = items_sent + 78;
                while (items_sent < phase_end)
                    send_random_frame();
            end
        end
    endtask

    task automatic test_longest_frame();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits(16'hFFFF, 16'd3);
        // largest length is accepted, then the open frame times out
        send_byte(START_BYTE);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_byte(8'hFF);
        send_byte(8'hFF);
        repeat (6) send_byte(8'($urandom));
        repeat (4) send_tick();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_frame();
        test_length_abort();
        test_tick_timeout();
        test_random_traffic();
        test_longest_frame();
        drain_results();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
